// ===== hdl/ffl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffl_pkg
// Shared types and constants for the linked free-list block allocator.
// ----------------------------------------------------------------------------
package ffl_pkg;

  localparam int ID_W       = 8;
  localparam int LINK_DEPTH = 1 << ID_W;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NO_BLOCK = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT = 3'b001,
    ST_IDLE = 3'b010,
    ST_LINK = 3'b100
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic init_wr;    // write one link of the power-up chain
    logic accept;     // item taken this cycle
    logic load_link;  // head takes the link read back from memory
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic init_last;      // last link of the chain being written
    logic alloc_advance;  // offered item is an allocate that moves the head
  } sts_t;

endpackage

// ===== hdl/ffl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffl_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ffl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/ffl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffl_ctrl
// Sequencer: power-up link sweep, item acceptance, head advance, result valid.
// ----------------------------------------------------------------------------
module ffl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  ffl_pkg::sts_t sts,
  output ffl_pkg::cmd_t cmd
);

  import ffl_pkg::*;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.init_wr   = (state == ST_INIT);
    cmd.accept    = accept;
    cmd.load_link = (state == ST_LINK);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (sts.init_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && sts.alloc_advance) state_next = ST_LINK;
      end
      ST_LINK: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/ffl_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffl_dp
// Datapath: head, tail, empty flag, link memory and result register.
// ----------------------------------------------------------------------------
module ffl_dp #(
  parameter int NUM_BLOCKS = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ffl_pkg::cmd_t            cmd,
  output ffl_pkg::sts_t            sts,
  input  logic                     mode,
  input  logic [ffl_pkg::ID_W-1:0] block_id,
  output logic                     status,
  output logic [ffl_pkg::ID_W-1:0] granted_id
);

  import ffl_pkg::*;

  // block numbers are 8 bits wide, so the pool never exceeds the link depth
  localparam int POOL_SIZE = (NUM_BLOCKS > LINK_DEPTH) ? LINK_DEPTH : NUM_BLOCKS;
  localparam logic [ID_W:0]   POOL_LIM  = (ID_W + 1)'(POOL_SIZE);
  localparam logic [ID_W-1:0] TAIL_INIT = ID_W'(POOL_SIZE - 1);
  localparam logic [ID_W-1:0] ID_LAST   = ID_W'(LINK_DEPTH - 1);

  logic [ID_W-1:0] head_block;
  logic [ID_W-1:0] tail_block;
  logic            list_empty;
  logic [ID_W-1:0] init_cnt;
  logic [ID_W-1:0] link_rd;

  logic            is_alloc;
  logic            rel_ok;
  logic            head_is_tail;
  logic            ram_we;
  logic [ID_W-1:0] ram_waddr;
  logic [ID_W-1:0] ram_wdata;

  assign is_alloc     = (mode == MODE_ALLOC);
  assign rel_ok       = (mode == MODE_RELEASE) && ({1'b0, block_id} < POOL_LIM);
  assign head_is_tail = (head_block == tail_block);

  always_comb begin
    sts.init_last     = (init_cnt == ID_LAST);
    sts.alloc_advance = is_alloc && !list_empty && !head_is_tail;
  end

  // link of the old tail points at the released block
  assign ram_we    = cmd.init_wr || (cmd.accept && rel_ok && !list_empty);
  assign ram_waddr = cmd.init_wr ? init_cnt : tail_block;
  assign ram_wdata = cmd.init_wr ? ID_W'(init_cnt + 1'b1) : block_id;

  ffl_ram #(
    .WIDTH (ID_W),
    .DEPTH (LINK_DEPTH)
  ) u_links (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.accept),
    .raddr (head_block),
    .rdata (link_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      init_cnt   <= '0;
      head_block <= '0;
      tail_block <= TAIL_INIT;
      list_empty <= 1'b0;
    end else begin
      if (cmd.init_wr) begin
        init_cnt <= init_cnt + 1'b1;
      end
      if (cmd.load_link) begin
        head_block <= link_rd;
      end
      if (cmd.accept) begin
        if (is_alloc) begin
          if (!list_empty && head_is_tail) list_empty <= 1'b1;
        end else if (rel_ok) begin
          tail_block <= block_id;
          if (list_empty) begin
            head_block <= block_id;
            list_empty <= 1'b0;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (is_alloc && list_empty) begin
        status     <= STATUS_NO_BLOCK;
        granted_id <= '0;
      end else if (is_alloc) begin
        status     <= STATUS_OK;
        granted_id <= head_block;
      end else begin
        status     <= STATUS_OK;
        granted_id <= '0;
      end
    end
  end

endmodule

// ===== hdl/fifo_free_list_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_free_list_block_allocator
// Pool allocator: free blocks kept as a linked queue (head, tail, link RAM).
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------
//  in      | in_valid / in_ready  | mode (0 allocate, 1 release), block_id
//  out     | out_valid / out_ready| status (1 = no free block), granted_id
//
//  Busy: an allocate that leaves blocks behind drops in_ready for the link
//  state, as the new head comes from the registered read of the link RAM.
//  A release, or an allocate that empties the list or fails, does not.
//  Reset: after rst the link RAM is chained i -> i+1 by a sweep over all
//  256 links; in_ready stays low during the sweep.
//  Stalls: the result sits in an output register; a new item is taken when
//  that register is empty or being read out in the same cycle.
//
//  Releases of block numbers outside the pool are ignored (status ok,
//  granted_id zero). Releasing an already free block is not checked.
//
module fifo_free_list_block_allocator #(
  parameter int NUM_BLOCKS = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     mode,
  input  logic [ffl_pkg::ID_W-1:0] block_id,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     status,
  output logic [ffl_pkg::ID_W-1:0] granted_id
);

  import ffl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: sweep, acceptance, head advance and result valid
  ffl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // queue pointers, link RAM and the result register
  ffl_dp #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .mode       (mode),
    .block_id   (block_id),
    .status     (status),
    .granted_id (granted_id)
  );

endmodule
